>>> rtl/grs_pkg.sv
// grs_pkg: shared types and constants for the group reverse stream reorder
// no dependencies; used by every module of the block

package grs_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 7;
    localparam int CNT_W         = 7;
    localparam int MAX_GROUP_DEF = 64;

    // one emission command: which bank, which direction, how many beats
    typedef struct packed {
        logic             bank;
        logic             rev;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    // queue status seen by the front end
    typedef struct packed {
        logic       full;
        logic [1:0] bank_busy;
    } t_qstat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_back_state;

endpackage

>>> rtl/group_reverse_stream_reorder.sv
// group_reverse_stream_reorder: reverses a stream in groups of group_size beats; a
// short last group closed by i_is_last is not reversed. input: one beat per cycle
// while a buffer bank is free; two banks let one group fill while the previous one
// drains. output: each result beat is read from a bank, then loaded into the output
// register when it is free, with an idle state between groups. synchronous reset
// clears control and sets group_size to 1; buffer is not cleared. depends on grs_pkg

module group_reverse_stream_reorder #(
    parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [grs_pkg::CFG_W-1:0]         i_cfg_group_size,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [grs_pkg::DATA_W-1:0] i_value,
    input  logic                              i_is_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [grs_pkg::DATA_W-1:0] o_value_res,
    output logic                              o_run_end
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic [grs_pkg::CFG_W-1:0]         r_group_size;
    grs_pkg::t_qstat                   qstat;
    grs_pkg::t_cmd                     push_cmd;
    grs_pkg::t_cmd                     head;
    logic                              push;
    logic                              pop;
    logic                              head_valid;
    logic                              wr_en;
    logic [AW:0]                       wr_addr;
    logic                              rd_en;
    logic [AW:0]                       rd_addr;
    logic signed [grs_pkg::DATA_W-1:0] rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= grs_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_group_size;
        end
    end

    grs_front #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (r_group_size),
        .i_valid      (i_valid),
        .i_is_last    (i_is_last),
        .o_stall      (o_stall),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr)
    );

    grs_buf #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    grs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_qstat      (qstat)
    );

    grs_back #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value_res  (o_value_res),
        .o_run_end    (o_run_end)
    );

endmodule

>>> rtl/grs_buf.sv
// grs_buf: two-bank group buffer, one write port and one registered read port
// depends on grs_pkg

module grs_buf #(
    parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
    parameter int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW:0]                       i_wr_addr,
    input  logic signed [grs_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW:0]                       i_rd_addr,
    output logic signed [grs_pkg::DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 2 * (2 ** AW);

    logic signed [grs_pkg::DATA_W-1:0] r_mem [0:DEPTH-1];
    logic signed [grs_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/grs_front.sv
// grs_front: accepts input beats, stores them and classifies each group
// depends on grs_pkg

module grs_front #(
    parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
    parameter int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [grs_pkg::CFG_W-1:0] i_group_size,
    input  logic                      i_valid,
    input  logic                      i_is_last,
    output logic                      o_stall,
    input  grs_pkg::t_qstat           i_qstat,
    output logic                      o_push,
    output grs_pkg::t_cmd             o_cmd,
    output logic                      o_wr_en,
    output logic [AW:0]               o_wr_addr
);

    localparam int CW = $clog2(MAX_GROUP + 1);

    logic [CW-1:0]             r_fill;
    logic                      r_bank;
    logic [grs_pkg::CFG_W-1:0] k_eff;
    logic [grs_pkg::CNT_W-1:0] n_cnt;
    logic                      full_grp;
    logic                      emit;
    logic                      accept;

    always_comb begin
        if (i_group_size == '0) begin
            k_eff = grs_pkg::CFG_W'(1);
        end else if (i_group_size > grs_pkg::CFG_W'(MAX_GROUP)) begin
            k_eff = grs_pkg::CFG_W'(MAX_GROUP);
        end else begin
            k_eff = i_group_size;
        end
    end

    assign n_cnt    = grs_pkg::CNT_W'(r_fill) + grs_pkg::CNT_W'(1);
    assign full_grp = (n_cnt >= k_eff);
    assign emit     = full_grp | i_is_last;

    // the bank being filled must not still be waiting to drain
    assign o_stall = i_qstat.full | i_qstat.bank_busy[r_bank];
    assign accept  = i_valid & ~o_stall;

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_bank, r_fill[AW-1:0]};
    assign o_push    = accept & emit;

    always_comb begin
        o_cmd.bank = r_bank;
        o_cmd.rev  = full_grp;
        o_cmd.cnt  = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bank <= 1'b0;
        end else if (accept) begin
            if (emit) begin
                r_fill <= '0;
                r_bank <= ~r_bank;
            end else begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

endmodule

>>> rtl/grs_queue.sv
// grs_queue: two-entry command queue between front end and drain engine
// depends on grs_pkg

module grs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  grs_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output grs_pkg::t_cmd   o_head,
    output logic            o_head_valid,
    output grs_pkg::t_qstat o_qstat
);

    grs_pkg::t_cmd r_ent [0:1];
    logic [1:0]    r_vld;
    logic [1:0]    n_vld;
    logic          r_wp;
    logic          r_rp;

    assign o_head       = r_ent[r_rp];
    assign o_head_valid = r_vld[r_rp];

    always_comb begin
        o_qstat.full         = &r_vld;
        o_qstat.bank_busy[0] = (r_vld[0] & ~r_ent[0].bank) | (r_vld[1] & ~r_ent[1].bank);
        o_qstat.bank_busy[1] = (r_vld[0] & r_ent[0].bank) | (r_vld[1] & r_ent[1].bank);
    end

    always_comb begin
        n_vld = r_vld;
        if (i_push) begin
            n_vld[r_wp] = 1'b1;
        end
        if (i_pop) begin
            n_vld[r_rp] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

>>> rtl/grs_back.sv
// grs_back: drains one queued group from the buffer into the output register
// depends on grs_pkg

module grs_back #(
    parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
    parameter int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  grs_pkg::t_cmd                     i_head,
    input  logic                              i_head_valid,
    output logic                              o_pop,
    output logic                              o_rd_en,
    output logic [AW:0]                       o_rd_addr,
    input  logic signed [grs_pkg::DATA_W-1:0] i_rd_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [grs_pkg::DATA_W-1:0] o_value_res,
    output logic                              o_run_end
);

    grs_pkg::t_back_state              r_state;
    grs_pkg::t_back_state              n_state;
    logic [grs_pkg::CNT_W-1:0]         r_idx;
    logic [grs_pkg::CNT_W-1:0]         n_idx;
    logic [grs_pkg::CNT_W-1:0]         offset;
    logic                              last_beat;
    logic                              out_free;
    logic                              load;
    logic                              r_ovld;
    logic signed [grs_pkg::DATA_W-1:0] r_oval;
    logic                              r_oend;

    assign offset    = i_head.rev ? (i_head.cnt - grs_pkg::CNT_W'(1) - r_idx) : r_idx;
    assign last_beat = (r_idx == i_head.cnt - grs_pkg::CNT_W'(1));
    assign out_free  = ~r_ovld | ~i_stall;
    assign o_rd_addr = {i_head.bank, offset[AW-1:0]};

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_rd_en = 1'b0;
        o_pop   = 1'b0;
        load    = 1'b0;
        case (r_state)
            grs_pkg::ST_IDLE: begin
                if (i_head_valid) begin
                    n_idx   = '0;
                    n_state = grs_pkg::ST_READ;
                end
            end
            grs_pkg::ST_READ: begin
                o_rd_en = 1'b1;
                n_state = grs_pkg::ST_LOAD;
            end
            grs_pkg::ST_LOAD: begin
                if (out_free) begin
                    load = 1'b1;
                    if (last_beat) begin
                        o_pop   = 1'b1;
                        n_state = grs_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + grs_pkg::CNT_W'(1);
                        n_state = grs_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = grs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grs_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load) begin
            r_ovld <= 1'b1;
        end else if (!i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_oval <= i_rd_data;
            r_oend <= last_beat;
        end
    end

    assign o_valid     = r_ovld;
    assign o_value_res = r_oval;
    assign o_run_end   = r_oend;

endmodule
